@@ rtl/core/vpsn_pkg.sv @@
// types, constants and saturating coordinate helpers for the path segment normalizer
package vpsn_pkg;

   // internal coordinate width; arithmetic saturates to this signed range
   localparam int COORD_W = 32;
   localparam int FIELD_W = 32;
   localparam int WIDE_W  = ((COORD_W > FIELD_W) ? COORD_W : FIELD_W) + 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [FIELD_W-1:0] field_type;

   localparam coord_type CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [3:0] {
      K_MOVE    = 4'd0,
      K_LINE    = 4'd1,
      K_HORIZ   = 4'd2,
      K_VERT    = 4'd3,
      K_CUBIC   = 4'd4,
      K_SMOOTH  = 4'd5,
      K_ARC     = 4'd6,
      K_CLOSE   = 4'd7,
      K_REPEAT  = 4'd8,
      K_END     = 4'd9,
      K_UNKNOWN = 4'd10
   } cmd_kind_type;

   typedef enum logic [2:0] {
      S_BEGIN      = 3'd0,
      S_LINE       = 3'd1,
      S_CUBIC      = 3'd2,
      S_ARC        = 3'd3,
      S_END_OPEN   = 3'd4,
      S_END_CLOSED = 3'd5,
      S_DONE       = 3'd6,
      S_ERROR      = 3'd7
   } seg_kind_type;

   typedef struct packed {
      logic [3:0] kind;
      logic       relative;
      field_type  p1_x;
      field_type  p1_y;
      field_type  p2_x;
      field_type  p2_y;
      field_type  end_x;
      field_type  end_y;
      logic       big_arc;
      logic       sweep;
   } req_type;

   typedef struct packed {
      seg_kind_type seg_kind;
      field_type    out_p1_x;
      field_type    out_p1_y;
      field_type    out_p2_x;
      field_type    out_p2_y;
      field_type    out_end_x;
      field_type    out_end_y;
      logic         out_big_arc;
      logic         out_sweep;
      logic         last;
   } rsp_type;

   // status from the segment calculator to the top level
   typedef struct packed {
      logic       halted;
      logic [1:0] count;
   } calc_stat_type;

   function automatic coord_type sat_c(wide_type v);
      if (v > wide_type'(CMAX)) begin
         return CMAX;
      end else if (v < wide_type'(CMIN)) begin
         return CMIN;
      end
      return coord_type'(v[COORD_W-1:0]);
   endfunction

   // absolute or relative operand, saturated
   function automatic coord_type place(field_type v, coord_type base, logic rel);
      coord_type s;
      s = sat_c(wide_type'(v));
      if (rel) begin
         return sat_c(wide_type'(base) + wide_type'(s));
      end
      return s;
   endfunction

   // smooth cubic: twice the current point minus the previous control point
   function automatic coord_type reflect(coord_type cur, coord_type prev);
      coord_type dbl;
      dbl = sat_c(wide_type'(cur) + wide_type'(cur));
      return sat_c(wide_type'(dbl) - wide_type'(prev));
   endfunction

   function automatic coord_type abs_sat(field_type v);
      wide_type w;
      w = wide_type'(v);
      return sat_c((w < 0) ? -w : w);
   endfunction

   function automatic field_type to_field(coord_type c);
      wide_type w;
      w = wide_type'(c);
      return field_type'(w[FIELD_W-1:0]);
   endfunction

endpackage

@@ rtl/core/vpsn_seg_calc.sv @@
// path state registers and the single-pass segment calculation for one command
module vpsn_seg_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  vpsn_pkg::req_type      cmd,
   input  logic                   commit,
   output vpsn_pkg::rsp_type      res0,
   output vpsn_pkg::rsp_type      res1,
   output vpsn_pkg::calc_stat_type stat
);

   vpsn_pkg::coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   vpsn_pkg::coord_type fig_x_ff, fig_x_in, fig_y_ff, fig_y_in;
   vpsn_pkg::coord_type ctrl_x_ff, ctrl_x_in, ctrl_y_ff, ctrl_y_in;
   logic prev_cubic_ff, prev_cubic_in;
   logic fig_open_ff, fig_open_in;
   logic held_valid_ff, held_valid_in;
   logic [3:0] held_cmd_ff, held_cmd_in;
   logic halted_ff, halted_in;

   logic [3:0] eff;
   vpsn_pkg::coord_type px, py, ax, ay, bx, by;
   logic pre_en, main_en;
   vpsn_pkg::seg_kind_type pre_kind;
   vpsn_pkg::rsp_type main_seg, end_seg;

   always_comb begin
      if (cmd.kind == vpsn_pkg::K_REPEAT) begin
         eff = held_valid_ff ? held_cmd_ff : vpsn_pkg::K_END;
      end else begin
         eff = cmd.kind;
      end

      px = vpsn_pkg::place(cmd.end_x, cur_x_ff, cmd.relative);
      py = vpsn_pkg::place(cmd.end_y, cur_y_ff, cmd.relative);
      bx = vpsn_pkg::place(cmd.p2_x, cur_x_ff, cmd.relative);
      by = vpsn_pkg::place(cmd.p2_y, cur_y_ff, cmd.relative);
      if (eff == vpsn_pkg::K_CUBIC) begin
         ax = vpsn_pkg::place(cmd.p1_x, cur_x_ff, cmd.relative);
         ay = vpsn_pkg::place(cmd.p1_y, cur_y_ff, cmd.relative);
      end else if (prev_cubic_ff) begin
         ax = vpsn_pkg::reflect(cur_x_ff, ctrl_x_ff);
         ay = vpsn_pkg::reflect(cur_y_ff, ctrl_y_ff);
      end else begin
         ax = cur_x_ff;
         ay = cur_y_ff;
      end

      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      fig_x_in      = fig_x_ff;
      fig_y_in      = fig_y_ff;
      ctrl_x_in     = ctrl_x_ff;
      ctrl_y_in     = ctrl_y_ff;
      prev_cubic_in = prev_cubic_ff;
      fig_open_in   = fig_open_ff;
      held_valid_in = held_valid_ff;
      held_cmd_in   = held_cmd_ff;
      halted_in     = halted_ff;

      pre_en   = 1'b0;
      pre_kind = vpsn_pkg::S_END_OPEN;
      main_en  = 1'b0;
      main_seg = '0;

      case (eff)
         vpsn_pkg::K_MOVE: begin
            pre_en             = fig_open_ff;
            main_en            = 1'b1;
            main_seg.seg_kind  = vpsn_pkg::S_BEGIN;
            main_seg.out_end_x = vpsn_pkg::to_field(px);
            main_seg.out_end_y = vpsn_pkg::to_field(py);
            fig_open_in        = 1'b1;
            cur_x_in           = px;
            cur_y_in           = py;
            fig_x_in           = px;
            fig_y_in           = py;
            prev_cubic_in      = 1'b0;
            held_cmd_in        = vpsn_pkg::K_LINE;
            held_valid_in      = 1'b1;
         end
         vpsn_pkg::K_LINE, vpsn_pkg::K_HORIZ, vpsn_pkg::K_VERT: begin
            if (eff != vpsn_pkg::K_VERT) begin
               cur_x_in = px;
            end
            if (eff != vpsn_pkg::K_HORIZ) begin
               cur_y_in = py;
            end
            main_en            = fig_open_ff;
            main_seg.seg_kind  = vpsn_pkg::S_LINE;
            main_seg.out_end_x = vpsn_pkg::to_field(cur_x_in);
            main_seg.out_end_y = vpsn_pkg::to_field(cur_y_in);
            prev_cubic_in      = 1'b0;
            held_cmd_in        = eff;
            held_valid_in      = 1'b1;
         end
         vpsn_pkg::K_CUBIC, vpsn_pkg::K_SMOOTH: begin
            main_en            = fig_open_ff;
            main_seg.seg_kind  = vpsn_pkg::S_CUBIC;
            main_seg.out_p1_x  = vpsn_pkg::to_field(ax);
            main_seg.out_p1_y  = vpsn_pkg::to_field(ay);
            main_seg.out_p2_x  = vpsn_pkg::to_field(bx);
            main_seg.out_p2_y  = vpsn_pkg::to_field(by);
            main_seg.out_end_x = vpsn_pkg::to_field(px);
            main_seg.out_end_y = vpsn_pkg::to_field(py);
            cur_x_in           = px;
            cur_y_in           = py;
            ctrl_x_in          = bx;
            ctrl_y_in          = by;
            prev_cubic_in      = 1'b1;
            held_cmd_in        = eff;
            held_valid_in      = 1'b1;
         end
         vpsn_pkg::K_ARC: begin
            main_en                = fig_open_ff;
            main_seg.seg_kind      = vpsn_pkg::S_ARC;
            main_seg.out_p1_x      = vpsn_pkg::to_field(vpsn_pkg::abs_sat(cmd.p1_x));
            main_seg.out_p1_y      = vpsn_pkg::to_field(vpsn_pkg::abs_sat(cmd.p1_y));
            main_seg.out_p2_x      = cmd.p2_x;
            main_seg.out_end_x     = vpsn_pkg::to_field(px);
            main_seg.out_end_y     = vpsn_pkg::to_field(py);
            main_seg.out_big_arc   = cmd.big_arc;
            main_seg.out_sweep     = cmd.sweep;
            cur_x_in               = px;
            cur_y_in               = py;
            prev_cubic_in          = 1'b0;
            held_cmd_in            = vpsn_pkg::K_ARC;
            held_valid_in          = 1'b1;
         end
         vpsn_pkg::K_CLOSE: begin
            main_en           = fig_open_ff;
            main_seg.seg_kind = vpsn_pkg::S_END_CLOSED;
            fig_open_in       = 1'b0;
            cur_x_in          = fig_x_ff;
            cur_y_in          = fig_y_ff;
            prev_cubic_in     = 1'b0;
            held_valid_in     = 1'b0;
         end
         vpsn_pkg::K_END: begin
            pre_en            = fig_open_ff;
            main_en           = 1'b1;
            main_seg.seg_kind = vpsn_pkg::S_DONE;
            fig_open_in       = 1'b0;
            halted_in         = 1'b1;
         end
         default: begin
            // unknown and unused kinds stop the stream with an error
            pre_en            = fig_open_ff;
            main_en           = 1'b1;
            main_seg.seg_kind = vpsn_pkg::S_ERROR;
            fig_open_in       = 1'b0;
            halted_in         = 1'b1;
         end
      endcase

      main_seg.last     = 1'b1;
      end_seg           = '0;
      end_seg.seg_kind  = pre_kind;

      if (pre_en) begin
         res0 = end_seg;
         res0.last = !main_en;
         res1 = main_seg;
         stat.count = main_en ? 2'd2 : 2'd1;
      end else begin
         res0 = main_seg;
         res1 = main_seg;
         stat.count = main_en ? 2'd1 : 2'd0;
      end
      stat.halted = halted_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         fig_x_ff      <= '0;
         fig_y_ff      <= '0;
         ctrl_x_ff     <= '0;
         ctrl_y_ff     <= '0;
         prev_cubic_ff <= 1'b0;
         fig_open_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         halted_ff     <= 1'b0;
      end else if (commit) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         fig_x_ff      <= fig_x_in;
         fig_y_ff      <= fig_y_in;
         ctrl_x_ff     <= ctrl_x_in;
         ctrl_y_ff     <= ctrl_y_in;
         prev_cubic_ff <= prev_cubic_in;
         fig_open_ff   <= fig_open_in;
         held_valid_ff <= held_valid_in;
         halted_ff     <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         held_cmd_ff <= held_cmd_in;
      end
   end

endmodule

@@ rtl/core/vpsn_rsp_buf.sv @@
// two-entry result buffer that drains the segments of one command in order
module vpsn_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [1:0]        push_count,
   input  vpsn_pkg::rsp_type push_res0,
   input  vpsn_pkg::rsp_type push_res1,
   output logic              can_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vpsn_pkg::rsp_type rsp_data
);

   logic [1:0] count_ff, count_in;
   vpsn_pkg::rsp_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic pop;

   always_comb begin
      pop      = rsp_valid && rsp_ready;
      // room once the last buffered segment leaves this cycle
      can_take = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         count_in = push_count;
         slot0_in = push_res0;
         slot1_in = push_res1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ rtl/core/vector_path_segment_normalizer.sv @@
// top level of the path segment normalizer: command register, calculator and result buffer
//
//   channel  direction  ports                          payload
//   req      in         req_valid req_ready req_data   vpsn_pkg::req_type
//   rsp      out        rsp_valid rsp_ready rsp_data   vpsn_pkg::rsp_type
//
// a command is registered, then worked out combinationally against the path state
// one command per cycle while each gives at most one segment and the receiver is ready; a command giving two
// segments holds the command register until the result buffer has room again
// synchronous active-high reset clears the path state and empties both registers
// after done or error every later command is taken and dropped until reset
module vector_path_segment_normalizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vpsn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vpsn_pkg::rsp_type rsp_data
);

   logic              cmd_valid_ff, cmd_valid_in;
   vpsn_pkg::req_type cmd_ff, cmd_in;
   vpsn_pkg::rsp_type res0, res1;
   vpsn_pkg::calc_stat_type stat;
   logic buf_take, advance, commit, push;

   always_comb begin
      advance      = cmd_valid_ff && (stat.halted || buf_take);
      commit       = cmd_valid_ff && !stat.halted && buf_take;
      push         = commit && (stat.count != 2'd0);
      req_ready    = !cmd_valid_ff || advance;
      cmd_valid_in = cmd_valid_ff;
      cmd_in       = cmd_ff;
      if (req_valid && req_ready) begin
         cmd_valid_in = 1'b1;
         cmd_in       = req_data;
      end else if (advance) begin
         cmd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   vpsn_seg_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .commit (commit),
      .res0   (res0),
      .res1   (res1),
      .stat   (stat)
   );

   vpsn_rsp_buf u_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_count (stat.count),
      .push_res0  (res0),
      .push_res1  (res1),
      .can_take   (buf_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/sv/vector_path_segment_normalizer_tb.sv @@
// testbench for the path segment normalizer, checked against a path state predictor
`timescale 1ns / 100ps

module vector_path_segment_normalizer_tb;

   typedef logic signed [vpsn_pkg::COORD_W+1:0] coord_sum_type;

   localparam vpsn_pkg::field_type UNIT      = 32'sh0001_0000;
   localparam int                  RUN_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   vpsn_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   vpsn_pkg::rsp_type rsp_data;

   // predicted path state
   vpsn_pkg::coord_type    path_x, path_y, start_x, start_y, ctl_x, ctl_y;
   logic                   after_cubic, fig_open, held_ok, stopped, err_flag;
   vpsn_pkg::cmd_kind_type held_kind;

   vpsn_pkg::rsp_type pending_segs[$];

   int  cmds_accepted  = 0;
   int  segs_checked   = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  burst_left     = 0;
   int  hold_off_left  = 0;
   bit  sender_gaps    = 1'b1;
   bit  receiver_stalls = 1'b1;
   logic [15:0] stall_pattern = '1;
   logic [3:0]  stall_phase   = '0;

   vector_path_segment_normalizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d segments outstanding",
                  cycle_count, pending_segs.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic vpsn_pkg::coord_type clamp_coord(coord_sum_type v);
      if (v > coord_sum_type'(vpsn_pkg::CMAX)) begin
         return vpsn_pkg::CMAX;
      end else if (v < coord_sum_type'(vpsn_pkg::CMIN)) begin
         return vpsn_pkg::CMIN;
      end
      return vpsn_pkg::coord_type'(v);
   endfunction

   function automatic vpsn_pkg::coord_type offset_point(vpsn_pkg::field_type v,
                                                        vpsn_pkg::coord_type base,
                                                        logic rel);
      if (rel) begin
         return clamp_coord(coord_sum_type'(base) + coord_sum_type'(v));
      end
      return v;
   endfunction

   // doubled point is clamped before the old control point comes off
   function automatic vpsn_pkg::coord_type mirror_ctl(vpsn_pkg::coord_type cur,
                                                      vpsn_pkg::coord_type prev);
      vpsn_pkg::coord_type dbl;
      dbl = clamp_coord(coord_sum_type'(cur) + coord_sum_type'(cur));
      return clamp_coord(coord_sum_type'(dbl) - coord_sum_type'(prev));
   endfunction

   function automatic vpsn_pkg::coord_type radius_mag(vpsn_pkg::field_type v);
      coord_sum_type w;
      w = coord_sum_type'(v);
      return clamp_coord((w < 0) ? -w : w);
   endfunction

   function automatic vpsn_pkg::rsp_type make_seg(vpsn_pkg::seg_kind_type kd,
                                                  vpsn_pkg::coord_type a,
                                                  vpsn_pkg::coord_type b,
                                                  vpsn_pkg::coord_type c,
                                                  vpsn_pkg::coord_type d,
                                                  vpsn_pkg::coord_type e,
                                                  vpsn_pkg::coord_type f,
                                                  logic lg, logic sw);
      vpsn_pkg::rsp_type s;
      s.seg_kind    = kd;
      s.out_p1_x    = a;
      s.out_p1_y    = b;
      s.out_p2_x    = c;
      s.out_p2_y    = d;
      s.out_end_x   = e;
      s.out_end_y   = f;
      s.out_big_arc = lg;
      s.out_sweep   = sw;
      s.last        = 1'b0;
      return s;
   endfunction

   task automatic reset_path_state();
      path_x = '0; path_y = '0; start_x = '0; start_y = '0; ctl_x = '0; ctl_y = '0;
      after_cubic = 1'b0; fig_open = 1'b0; held_ok = 1'b0; stopped = 1'b0;
      err_flag = 1'b0; held_kind = vpsn_pkg::K_LINE;
   endtask

   task automatic predict_segments(input vpsn_pkg::req_type c);
      vpsn_pkg::rsp_type   segs[$];
      logic [3:0]          k;
      vpsn_pkg::coord_type x, y, ax, ay, bx, by;
      if (stopped) return;
      k = c.kind;
      if (k == vpsn_pkg::K_REPEAT) k = held_ok ? held_kind : vpsn_pkg::K_END;
      case (k)
         vpsn_pkg::K_MOVE: begin
            x = offset_point(c.end_x, path_x, c.relative);
            y = offset_point(c.end_y, path_y, c.relative);
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_END_OPEN, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
            end
            segs.push_back(make_seg(vpsn_pkg::S_BEGIN, 0, 0, 0, 0, x, y, 1'b0, 1'b0));
            fig_open = 1'b1;
            path_x = x; path_y = y; start_x = x; start_y = y;
            after_cubic = 1'b0;
            held_kind = vpsn_pkg::K_LINE; held_ok = 1'b1;
         end
         vpsn_pkg::K_LINE, vpsn_pkg::K_HORIZ, vpsn_pkg::K_VERT: begin
            x = (k == vpsn_pkg::K_VERT)  ? path_x : offset_point(c.end_x, path_x, c.relative);
            y = (k == vpsn_pkg::K_HORIZ) ? path_y : offset_point(c.end_y, path_y, c.relative);
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_LINE, 0, 0, 0, 0, x, y, 1'b0, 1'b0));
            end
            path_x = x; path_y = y;
            after_cubic = 1'b0;
            held_kind = vpsn_pkg::cmd_kind_type'(k); held_ok = 1'b1;
         end
         vpsn_pkg::K_CUBIC, vpsn_pkg::K_SMOOTH: begin
            bx = offset_point(c.p2_x, path_x, c.relative);
            by = offset_point(c.p2_y, path_y, c.relative);
            x  = offset_point(c.end_x, path_x, c.relative);
            y  = offset_point(c.end_y, path_y, c.relative);
            if (k == vpsn_pkg::K_CUBIC) begin
               ax = offset_point(c.p1_x, path_x, c.relative);
               ay = offset_point(c.p1_y, path_y, c.relative);
            end else if (after_cubic) begin
               ax = mirror_ctl(path_x, ctl_x);
               ay = mirror_ctl(path_y, ctl_y);
            end else begin
               ax = path_x;
               ay = path_y;
            end
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_CUBIC, ax, ay, bx, by, x, y, 1'b0, 1'b0));
            end
            path_x = x; path_y = y; ctl_x = bx; ctl_y = by;
            after_cubic = 1'b1;
            held_kind = vpsn_pkg::cmd_kind_type'(k); held_ok = 1'b1;
         end
         vpsn_pkg::K_ARC: begin
            x = offset_point(c.end_x, path_x, c.relative);
            y = offset_point(c.end_y, path_y, c.relative);
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_ARC, radius_mag(c.p1_x), radius_mag(c.p1_y),
                                       c.p2_x, 0, x, y, c.big_arc, c.sweep));
            end
            path_x = x; path_y = y;
            after_cubic = 1'b0;
            held_kind = vpsn_pkg::K_ARC; held_ok = 1'b1;
         end
         vpsn_pkg::K_CLOSE: begin
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_END_CLOSED, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
            end
            fig_open = 1'b0;
            path_x = start_x; path_y = start_y;
            after_cubic = 1'b0;
            held_ok = 1'b0;
         end
         vpsn_pkg::K_END: begin
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_END_OPEN, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
            end
            fig_open = 1'b0;
            segs.push_back(make_seg(vpsn_pkg::S_DONE, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
            stopped = 1'b1;
         end
         default: begin
            if (fig_open) begin
               segs.push_back(make_seg(vpsn_pkg::S_END_OPEN, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
            end
            fig_open = 1'b0;
            segs.push_back(make_seg(vpsn_pkg::S_ERROR, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
            err_flag = 1'b1;
            stopped = 1'b1;
         end
      endcase
      if (segs.size() > 0) segs[segs.size()-1].last = 1'b1;
      foreach (segs[i]) pending_segs.push_back(segs[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 30) begin
         $display("mismatch on segment %0d, %s: got %h, wanted %h",
                  segs_checked, what, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      vpsn_pkg::rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (pending_segs.size() == 0) begin
            report_mismatch("unexpected transaction, seg_kind", 32'(got.seg_kind), '0);
         end else begin
            want = pending_segs.pop_front();
            if (got.seg_kind !== want.seg_kind)
               report_mismatch("seg_kind", 32'(got.seg_kind), 32'(want.seg_kind));
            if (got.out_p1_x !== want.out_p1_x)
               report_mismatch("out_p1_x", got.out_p1_x, want.out_p1_x);
            if (got.out_p1_y !== want.out_p1_y)
               report_mismatch("out_p1_y", got.out_p1_y, want.out_p1_y);
            if (got.out_p2_x !== want.out_p2_x)
               report_mismatch("out_p2_x", got.out_p2_x, want.out_p2_x);
            if (got.out_p2_y !== want.out_p2_y)
               report_mismatch("out_p2_y", got.out_p2_y, want.out_p2_y);
            if (got.out_end_x !== want.out_end_x)
               report_mismatch("out_end_x", got.out_end_x, want.out_end_x);
            if (got.out_end_y !== want.out_end_y)
               report_mismatch("out_end_y", got.out_end_y, want.out_end_y);
            if (got.out_big_arc !== want.out_big_arc)
               report_mismatch("out_big_arc", 32'(got.out_big_arc), 32'(want.out_big_arc));
            if (got.out_sweep !== want.out_sweep)
               report_mismatch("out_sweep", 32'(got.out_sweep), 32'(want.out_sweep));
            if (got.last !== want.last)
               report_mismatch("last", 32'(got.last), 32'(want.last));
         end
         segs_checked++;
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else if (!receiver_stalls) begin
         rsp_ready <= 1'b1;
      end else begin
         if (stall_phase == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pattern = 16'($urandom);
               1: stall_pattern = 16'($urandom | $urandom);
               default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
         end
         rsp_ready <= stall_pattern[stall_phase];
         stall_phase = stall_phase + 1'b1;
      end
   end

   // ---------------------------------------------------------------- sender

   function automatic vpsn_pkg::req_type path_cmd(logic [3:0] kd, logic rel,
                                                  vpsn_pkg::field_type p1x,
                                                  vpsn_pkg::field_type p1y,
                                                  vpsn_pkg::field_type p2x,
                                                  vpsn_pkg::field_type p2y,
                                                  vpsn_pkg::field_type ex,
                                                  vpsn_pkg::field_type ey,
                                                  logic lg, logic sw);
      vpsn_pkg::req_type c;
      c.kind = kd; c.relative = rel;
      c.p1_x = p1x; c.p1_y = p1y; c.p2_x = p2x; c.p2_y = p2y;
      c.end_x = ex; c.end_y = ey;
      c.big_arc = lg; c.sweep = sw;
      return c;
   endfunction

   function automatic vpsn_pkg::field_type rand_coord();
      case ($urandom_range(0, 9))
         0: return vpsn_pkg::CMAX;
         1: return vpsn_pkg::CMIN;
         2: return '0;
         3: return -1;
         8, 9: return vpsn_pkg::field_type'($urandom);
         default: return vpsn_pkg::field_type'($urandom_range(0, 32'h0020_0000))
                         - 32'sh0010_0000;
      endcase
   endfunction

   // called and returns at a falling edge; valid stays up between items of a burst
   task automatic send_cmd(input vpsn_pkg::req_type c);
      logic taken;
      taken = 1'b0;
      req_data  = c;
      req_valid = 1'b1;
      while (!taken) begin
         @(posedge clock);
         if (req_ready) begin
            taken = 1'b1;
            predict_segments(c);
            cmds_accepted++;
         end
         @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      if (sender_gaps && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_segs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_draw(input bit allow_close);
      vpsn_pkg::cmd_kind_type kd;
      case ($urandom_range(0, allow_close ? 7 : 6))
         0: kd = vpsn_pkg::K_LINE;
         1: kd = vpsn_pkg::K_HORIZ;
         2: kd = vpsn_pkg::K_VERT;
         3: kd = vpsn_pkg::K_CUBIC;
         4: kd = vpsn_pkg::K_SMOOTH;
         5: kd = vpsn_pkg::K_ARC;
         6: kd = vpsn_pkg::K_REPEAT;
         default: kd = vpsn_pkg::K_CLOSE;
      endcase
      // a repeat with nothing held would halt the block
      if (kd == vpsn_pkg::K_REPEAT && !held_ok) kd = vpsn_pkg::K_LINE;
      send_cmd(path_cmd(kd, 1'($urandom), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), 1'($urandom), 1'($urandom)));
   endtask

   task automatic send_random_figure();
      if (!fig_open && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) send_random_draw(1'b1);
      end
      send_cmd(path_cmd(vpsn_pkg::K_MOVE, 1'($urandom), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        1'($urandom), 1'($urandom)));
      repeat ($urandom_range(1, 12)) send_random_draw(1'b0);
      if ($urandom_range(0, 2) != 0) begin
         send_cmd(path_cmd(vpsn_pkg::K_CLOSE, 1'($urandom), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           1'($urandom), 1'($urandom)));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_commands();
      send_cmd(path_cmd(vpsn_pkg::K_LINE,  1'b0, 0, 0, 0, 0, 3*UNIT, 4*UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_CLOSE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_MOVE,  1'b0, 0, 0, 0, 0, UNIT, 2*UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_LINE,  1'b1, 0, 0, 0, 0, UNIT, -UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_HORIZ, 1'b0, 0, 0, 0, 0, 5*UNIT, 9*UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_VERT,  1'b1, 0, 0, 0, 0, 7*UNIT, -3*UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_CUBIC, 1'b0, UNIT, UNIT, 2*UNIT, 3*UNIT, 4*UNIT, UNIT,
                        1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_SMOOTH, 1'b1, 9*UNIT, 9*UNIT, UNIT, 2*UNIT, 3*UNIT, -UNIT,
                        1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_REPEAT, 1'b1, 0, 0, -UNIT, UNIT, UNIT, UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_ARC, 1'b0, -2*UNIT, 3*UNIT, 45*UNIT, 5, UNIT, UNIT,
                        1'b1, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_REPEAT, 1'b1, UNIT, -UNIT, -30*UNIT, 7, 2*UNIT, 0,
                        1'b0, 1'b1));
      send_cmd(path_cmd(vpsn_pkg::K_HORIZ, 1'b1, 0, 0, 0, 0, -UNIT, 0, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_REPEAT, 1'b0, 0, 0, 0, 0, 6*UNIT, 6*UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_CLOSE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
      // smooth with no figure and no cubic before it: control starts at the point
      send_cmd(path_cmd(vpsn_pkg::K_SMOOTH, 1'b0, 0, 0, 2*UNIT, 2*UNIT, 3*UNIT, 3*UNIT,
                        1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_MOVE,   1'b1, 0, 0, 0, 0, -UNIT, -UNIT, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_REPEAT, 1'b1, 0, 0, 0, 0, UNIT, 0, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_MOVE,   1'b0, 0, 0, 0, 0, 8*UNIT, 8*UNIT, 1'b0, 1'b0));
   endtask

   task automatic test_directed_extremes();
      send_cmd(path_cmd(vpsn_pkg::K_MOVE, 1'b0, 0, 0, 0, 0, vpsn_pkg::CMAX, vpsn_pkg::CMIN,
                        1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_LINE, 1'b1, 0, 0, 0, 0, vpsn_pkg::CMAX, vpsn_pkg::CMIN,
                        1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_CUBIC, 1'b0, 0, 0, vpsn_pkg::CMIN, vpsn_pkg::CMAX,
                        vpsn_pkg::CMAX, vpsn_pkg::CMIN, 1'b0, 1'b0));
      // both the doubling and the subtraction clamp here
      send_cmd(path_cmd(vpsn_pkg::K_SMOOTH, 1'b0, 0, 0, vpsn_pkg::CMAX, vpsn_pkg::CMIN,
                        vpsn_pkg::CMAX, vpsn_pkg::CMIN, 1'b0, 1'b0));
      // doubling clamps but the difference does not
      send_cmd(path_cmd(vpsn_pkg::K_SMOOTH, 1'b1, vpsn_pkg::CMIN, vpsn_pkg::CMAX, -1, 1,
                        vpsn_pkg::CMIN, vpsn_pkg::CMAX, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_ARC, 1'b1, vpsn_pkg::CMIN, vpsn_pkg::CMAX,
                        vpsn_pkg::CMIN, -1, vpsn_pkg::CMIN, vpsn_pkg::CMIN, 1'b1, 1'b1));
      send_cmd(path_cmd(vpsn_pkg::K_ARC, 1'b0, -1, vpsn_pkg::CMIN, vpsn_pkg::CMAX,
                        vpsn_pkg::CMAX, -1, -1, 1'b0, 1'b0));
      send_cmd(path_cmd(vpsn_pkg::K_VERT, 1'b1, -1, -1, -1, -1, -1, vpsn_pkg::CMIN,
                        1'b1, 1'b1));
      wait_drained();
   endtask

   task automatic test_random_paths();
      while (cmds_accepted < 440) begin
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         send_random_figure();
      end
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_backpressure();
      sender_gaps = 1'b0;
      @(posedge clock);
      hold_off_left = 150;
      @(negedge clock);
      repeat (4) send_random_figure();
      sender_gaps = 1'b1;
      wait_drained();
   endtask

   task automatic test_termination();
      int how;
      how = $urandom_range(0, 2);
      if (how == 0) begin
         send_cmd(path_cmd(vpsn_pkg::K_END, 1'($urandom), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           1'b0, 1'b0));
      end else if (how == 1) begin
         send_cmd(path_cmd(4'(vpsn_pkg::K_UNKNOWN) + 4'($urandom_range(0, 5)), 1'($urandom),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), 1'($urandom), 1'($urandom)));
      end else begin
         // repeat with nothing held behaves as end
         if (held_ok) begin
            send_cmd(path_cmd(vpsn_pkg::K_CLOSE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
         end
         send_cmd(path_cmd(vpsn_pkg::K_REPEAT, 1'($urandom), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           1'b0, 1'b0));
      end
      // everything after the halt is taken and dropped
      repeat (6) begin
         send_cmd(path_cmd(4'($urandom_range(0, 15)), 1'($urandom), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), 1'($urandom), 1'($urandom)));
      end
      wait_drained();
   endtask

   initial begin
      reset_path_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_commands();
      test_directed_extremes();
      test_random_paths();
      test_backpressure();
      test_termination();

      repeat (16) @(posedge clock);
      $display("sent %0d path commands, checked %0d segments, %0d mismatches",
               cmds_accepted, segs_checked, mismatch_count);
      $display("covered moves, lines, cubics, smooth reflection, arcs, closes, repeats, %s",
               err_flag ? "halt on an unknown command" : "halt on end");
      if (mismatch_count == 0 && pending_segs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
